/* hw/rtl/stc_pkg.sv */
package stc_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int REL_BITS       = 3;
   localparam int NUM_ORIENT     = 10;
   localparam int LATENCY        = 4;

   typedef enum logic [REL_BITS-1:0] {
      REL_OUTSIDE      = 3'd0,
      REL_OVERLAPPING  = 3'd1,
      REL_TOUCHING     = 3'd2,
      REL_INSIDE       = 3'd3,
      REL_INTERSECTING = 3'd4
   } relation_type;

   // sign of an exact value: negative, zero, or (neither) positive
   typedef struct packed {
      logic neg;
      logic zero;
   } sign_type;

   // sign of the product of two signs
   function automatic sign_type sign_mul(sign_type a, sign_type b);
      sign_type r;
      r.zero = a.zero | b.zero;
      r.neg  = ~r.zero & (a.neg ^ b.neg);
      return r;
   endfunction

endpackage

/* hw/rtl/stc_orient.sv */
// Exact orientation sign of (d x p): sign(d_x*p_y - p_x*d_y).
// Two register stages: products, then the sign of their difference.
module stc_orient #(
   parameter int COORD_BITS = stc_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic signed [COORD_BITS:0]  d_x,
   input  logic signed [COORD_BITS:0]  d_y,
   input  logic signed [COORD_BITS:0]  p_x,
   input  logic signed [COORD_BITS:0]  p_y,
   output stc_pkg::sign_type           sign
);

   localparam int W  = COORD_BITS + 1;
   localparam int PW = 2 * W;

   logic signed [PW-1:0] prod_a_ff, prod_b_ff;
   logic signed [PW:0]   diff;
   stc_pkg::sign_type    sign_ff, sign_in;

   always_ff @(posedge clock) begin
      prod_a_ff <= PW'(d_x) * PW'(p_y);
      prod_b_ff <= PW'(p_x) * PW'(d_y);
   end

   always_comb begin
      diff         = {prod_a_ff[PW-1], prod_a_ff} - {prod_b_ff[PW-1], prod_b_ff};
      sign_in.neg  = diff[PW];
      sign_in.zero = (diff == '0);
   end

   always_ff @(posedge clock) begin
      sign_ff <= sign_in;
   end

   assign sign = sign_ff;

endmodule

/* hw/rtl/segment_triangle_classify.sv */
// Segment versus triangle classifier. One word is taken on every clock in
// which start is high; busy never rises, since the pipeline has no stall and
// the receiver cannot hold results off. Each word's relation appears on
// rsp_relation with rsp_valid high once it has passed the registers for
// differences, products, difference sign and classification, and a new word may
// follow every cycle: ten orientation units of two multipliers each are fully
// pipelined, one orientation test per unit per clock.
module segment_triangle_classify #(
   parameter int COORD_BITS = stc_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_BITS-1:0]  req_seg_start_x,
   input  logic signed [COORD_BITS-1:0]  req_seg_start_y,
   input  logic signed [COORD_BITS-1:0]  req_seg_end_x,
   input  logic signed [COORD_BITS-1:0]  req_seg_end_y,
   input  logic signed [COORD_BITS-1:0]  req_tri_v0_x,
   input  logic signed [COORD_BITS-1:0]  req_tri_v0_y,
   input  logic signed [COORD_BITS-1:0]  req_tri_v1_x,
   input  logic signed [COORD_BITS-1:0]  req_tri_v1_y,
   input  logic signed [COORD_BITS-1:0]  req_tri_v2_x,
   input  logic signed [COORD_BITS-1:0]  req_tri_v2_y,
   output logic                          rsp_valid,
   output logic [stc_pkg::REL_BITS-1:0]  rsp_relation
);

   localparam int C = COORD_BITS;
   localparam int N = stc_pkg::NUM_ORIENT;

   // orientation tests: edge V0V1, V1V2, V2V0 against S0/S1, the triangle
   // itself, and segment S0S1 against each vertex
   localparam int O_E01_S0 = 0;
   localparam int O_E01_S1 = 1;
   localparam int O_E12_S0 = 2;
   localparam int O_E12_S1 = 3;
   localparam int O_E20_S0 = 4;
   localparam int O_E20_S1 = 5;
   localparam int O_TRI    = 6;
   localparam int O_SEG_V0 = 7;
   localparam int O_SEG_V1 = 8;
   localparam int O_SEG_V2 = 9;

   logic signed [C:0] s0x, s0y, s1x, s1y, v0x, v0y, v1x, v1y, v2x, v2y;
   logic signed [C:0] dx_in [N];
   logic signed [C:0] dy_in [N];
   logic signed [C:0] px_in [N];
   logic signed [C:0] py_in [N];
   logic signed [C:0] dx_ff [N];
   logic signed [C:0] dy_ff [N];
   logic signed [C:0] px_ff [N];
   logic signed [C:0] py_ff [N];

   stc_pkg::sign_type o [N];

   logic [stc_pkg::LATENCY-2:0] valid_ff;
   logic                        rsp_valid_ff;
   stc_pkg::relation_type       rel_in, rel_ff;

   stc_pkg::sign_type f1, f2, f3, f4, f5, f6, f7, f8;
   logic any_out, any_overlap, any_touch, all_in;

   assign busy = 1'b0;

   // stage 1: sign-extended differences
   always_comb begin
      s0x = {req_seg_start_x[C-1], req_seg_start_x};
      s0y = {req_seg_start_y[C-1], req_seg_start_y};
      s1x = {req_seg_end_x[C-1], req_seg_end_x};
      s1y = {req_seg_end_y[C-1], req_seg_end_y};
      v0x = {req_tri_v0_x[C-1], req_tri_v0_x};
      v0y = {req_tri_v0_y[C-1], req_tri_v0_y};
      v1x = {req_tri_v1_x[C-1], req_tri_v1_x};
      v1y = {req_tri_v1_y[C-1], req_tri_v1_y};
      v2x = {req_tri_v2_x[C-1], req_tri_v2_x};
      v2y = {req_tri_v2_y[C-1], req_tri_v2_y};

      dx_in[O_E01_S0] = v1x - v0x;  dy_in[O_E01_S0] = v1y - v0y;
      px_in[O_E01_S0] = s0x - v0x;  py_in[O_E01_S0] = s0y - v0y;
      dx_in[O_E01_S1] = v1x - v0x;  dy_in[O_E01_S1] = v1y - v0y;
      px_in[O_E01_S1] = s1x - v0x;  py_in[O_E01_S1] = s1y - v0y;

      dx_in[O_E12_S0] = v2x - v1x;  dy_in[O_E12_S0] = v2y - v1y;
      px_in[O_E12_S0] = s0x - v1x;  py_in[O_E12_S0] = s0y - v1y;
      dx_in[O_E12_S1] = v2x - v1x;  dy_in[O_E12_S1] = v2y - v1y;
      px_in[O_E12_S1] = s1x - v1x;  py_in[O_E12_S1] = s1y - v1y;

      dx_in[O_E20_S0] = v0x - v2x;  dy_in[O_E20_S0] = v0y - v2y;
      px_in[O_E20_S0] = s0x - v2x;  py_in[O_E20_S0] = s0y - v2y;
      dx_in[O_E20_S1] = v0x - v2x;  dy_in[O_E20_S1] = v0y - v2y;
      px_in[O_E20_S1] = s1x - v2x;  py_in[O_E20_S1] = s1y - v2y;

      // one test serves all three cyclic triangle orientations
      dx_in[O_TRI]    = v1x - v0x;  dy_in[O_TRI]    = v1y - v0y;
      px_in[O_TRI]    = v2x - v0x;  py_in[O_TRI]    = v2y - v0y;

      dx_in[O_SEG_V0] = s1x - s0x;  dy_in[O_SEG_V0] = s1y - s0y;
      px_in[O_SEG_V0] = v0x - s0x;  py_in[O_SEG_V0] = v0y - s0y;
      dx_in[O_SEG_V1] = s1x - s0x;  dy_in[O_SEG_V1] = s1y - s0y;
      px_in[O_SEG_V1] = v1x - s0x;  py_in[O_SEG_V1] = v1y - s0y;
      dx_in[O_SEG_V2] = s1x - s0x;  dy_in[O_SEG_V2] = s1y - s0y;
      px_in[O_SEG_V2] = v2x - s0x;  py_in[O_SEG_V2] = v2y - s0y;
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      px_ff <= px_in;
      py_ff <= py_in;
   end

   // stages 2 and 3
   for (genvar i = 0; i < N; i++) begin : g_orient
      stc_orient #(
         .COORD_BITS (COORD_BITS)
      ) u_orient (
         .clock (clock),
         .d_x   (dx_ff[i]),
         .d_y   (dy_ff[i]),
         .p_x   (px_ff[i]),
         .p_y   (py_ff[i]),
         .sign  (o[i])
      );
   end

   // stage 4: side tests and classification
   always_comb begin
      f1 = stc_pkg::sign_mul(o[O_E01_S0], o[O_TRI]);
      f2 = stc_pkg::sign_mul(o[O_E01_S1], o[O_TRI]);
      f3 = stc_pkg::sign_mul(o[O_E12_S0], o[O_TRI]);
      f4 = stc_pkg::sign_mul(o[O_E12_S1], o[O_TRI]);
      f5 = stc_pkg::sign_mul(o[O_E20_S0], o[O_TRI]);
      f6 = stc_pkg::sign_mul(o[O_E20_S1], o[O_TRI]);
      f7 = stc_pkg::sign_mul(o[O_SEG_V0], o[O_SEG_V1]);
      f8 = stc_pkg::sign_mul(o[O_SEG_V1], o[O_SEG_V2]);

      any_out = (f1.neg & f2.neg) | (f3.neg & f4.neg) | (f5.neg & f6.neg) |
                (~f7.neg & ~f7.zero & ~f8.neg & ~f8.zero);
      any_overlap = (f1.zero & f2.zero) | (f3.zero & f4.zero) | (f5.zero & f6.zero);
      any_touch = ((f1.neg | f1.zero) & (f2.neg | f2.zero)) |
                  ((f3.neg | f3.zero) & (f4.neg | f4.zero)) |
                  ((f5.neg | f5.zero) & (f6.neg | f6.zero)) |
                  (~f7.neg & ~f8.neg);
      all_in = ~(f1.neg | f1.zero | f2.neg | f2.zero | f3.neg | f3.zero |
                 f4.neg | f4.zero | f5.neg | f5.zero | f6.neg | f6.zero);

      if (any_out) begin
         rel_in = stc_pkg::REL_OUTSIDE;
      end else if (any_overlap) begin
         rel_in = stc_pkg::REL_OVERLAPPING;
      end else if (any_touch) begin
         rel_in = stc_pkg::REL_TOUCHING;
      end else if (all_in) begin
         rel_in = stc_pkg::REL_INSIDE;
      end else begin
         rel_in = stc_pkg::REL_INTERSECTING;
      end
   end

   always_ff @(posedge clock) begin
      rel_ff <= rel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[stc_pkg::LATENCY-3:0], start & ~busy};
         rsp_valid_ff <= valid_ff[stc_pkg::LATENCY-2];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_relation = rel_ff;

   a_word_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted word produced no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##4 !rsp_valid)
      else $error("result without an accepted word");

   a_inside_nondegen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_relation == stc_pkg::REL_INSIDE) |-> !$past(o[O_TRI].zero))
      else $error("inside reported for a degenerate triangle");

   a_outside_seg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_relation == stc_pkg::REL_INSIDE) |->
      !$past(f7.neg && f7.zero))
      else $error("side test sign encoding broken");

endmodule
